### hw/rtl/inv256_pkg.sv
// Shared types and constants for the 256-bit inverse modulo 2^256 block.
package inv256_pkg;

  localparam int unsigned LIMB_BITS  = 64;
  localparam int unsigned TOTAL_BITS = 256;

  // One input beat: the operand, most significant limb first.
  typedef struct packed {
    logic [LIMB_BITS-1:0] value_limb3;
    logic [LIMB_BITS-1:0] value_limb2;
    logic [LIMB_BITS-1:0] value_limb1;
    logic [LIMB_BITS-1:0] value_limb0;
  } value_t;

  // One output beat: the inverse and the even-operand flag.
  typedef struct packed {
    logic [LIMB_BITS-1:0] inverse_limb3;
    logic [LIMB_BITS-1:0] inverse_limb2;
    logic [LIMB_BITS-1:0] inverse_limb1;
    logic [LIMB_BITS-1:0] inverse_limb0;
    logic                 not_invertible;
  } inverse_t;

  // Contents of one pipeline stage register.
  typedef struct packed {
    logic                  valid;
    logic [TOTAL_BITS-1:0] operand;
    logic [TOTAL_BITS-1:0] residual;
    logic [TOTAL_BITS-1:0] partial;
  } stage_t;

endpackage

### hw/rtl/inverse_mod_2_pow_256.sv
// Top level: pipelined inverse of an odd 256-bit integer modulo 2^256.
// A new operand can enter every cycle unless the pipeline is frozen. Each operand passes
// through every stage register in turn before its result is presented. There is one
// pipeline stage per bit of the inverse, and each stage holds one 256-bit conditional
// subtract. The whole pipeline moves together and freezes while a finished beat waits
// at the output. An even operand yields not_invertible set and an all-zero inverse.
module inverse_mod_2_pow_256 (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  value_valid,
  output logic                  value_ready,
  input  inv256_pkg::value_t    value,
  output logic                  inverse_valid,
  input  logic                  inverse_ready,
  output inv256_pkg::inverse_t  inverse
);

  localparam int unsigned STAGES = inv256_pkg::TOTAL_BITS;

  inv256_pkg::stage_t stages [STAGES+1];
  inv256_pkg::stage_t last;
  logic               advance;
  logic               even;

  // The pipeline moves when the output beat is empty or being taken.
  assign advance     = !stages[STAGES].valid || inverse_ready;
  assign value_ready = advance;

  // Entry: residual starts at one, inverse at zero.
  always_comb begin
    stages[0].valid    = value_valid;
    stages[0].operand  = {value.value_limb3, value.value_limb2,
                          value.value_limb1, value.value_limb0};
    stages[0].residual = {{(inv256_pkg::TOTAL_BITS-1){1'b0}}, 1'b1};
    stages[0].partial  = '0;
  end

  // One stage per bit.
  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    inv256_stage #(
      .BIT_POS(g)
    ) u_stage (
      .clk      (clk),
      .rst      (rst),
      .advance  (advance),
      .stage_in (stages[g]),
      .stage_out(stages[g+1])
    );
  end

  // Output beat; even operands are flagged and zeroed.
  always_comb begin
    last                    = stages[STAGES];
    even                    = !last.operand[0];
    inverse_valid           = last.valid;
    inverse.not_invertible  = even;
    inverse.inverse_limb0   = even ? '0 : last.partial[63:0];
    inverse.inverse_limb1   = even ? '0 : last.partial[127:64];
    inverse.inverse_limb2   = even ? '0 : last.partial[191:128];
    inverse.inverse_limb3   = even ? '0 : last.partial[255:192];
  end

  // An odd operand always gives an odd inverse.
  a_odd_inverse: assert property (@(posedge clk) disable iff (rst)
    (inverse_valid && !inverse.not_invertible) |-> inverse.inverse_limb0[0])
    else $error("inverse of odd operand is even");

  // A valid result of an odd operand leaves no residual behind.
  a_residual_clear: assert property (@(posedge clk) disable iff (rst)
    (inverse_valid && !inverse.not_invertible) |-> (last.residual == '0))
    else $error("residual not cleared at pipeline end");

  // A frozen pipeline keeps its output beat.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (inverse_valid && !inverse_ready) |=> (inverse_valid && $stable(last.partial)))
    else $error("output beat changed during stall");

endmodule

### hw/rtl/inv256_stage.sv
// One bit step of the Hensel lifting pipeline: settles one bit of the inverse.
module inv256_stage #(
  parameter int unsigned BIT_POS = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  inv256_pkg::stage_t   stage_in,
  output inv256_pkg::stage_t   stage_out
);

  logic [inv256_pkg::TOTAL_BITS-1:0] shifted;
  inv256_pkg::stage_t                stage_next;

  // Where the residual still has this bit set, take the shifted operand off it
  // and set the same bit of the inverse. For an odd operand, lower residual bits are already zero.
  always_comb begin
    shifted    = stage_in.operand << BIT_POS;
    stage_next = stage_in;
    if (stage_in.residual[BIT_POS]) begin
      stage_next.residual         = stage_in.residual - shifted;
      stage_next.partial[BIT_POS] = 1'b1;
    end
  end

  // Stage register; only the valid bit is reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_out.valid <= 1'b0;
    end else if (advance) begin
      stage_out.valid <= stage_next.valid;
    end
    if (advance) begin
      stage_out.operand  <= stage_next.operand;
      stage_out.residual <= stage_next.residual;
      stage_out.partial  <= stage_next.partial;
    end
  end

endmodule

### dv/inverse_mod_2_pow_256_tb.sv
// Testbench for the 256-bit inverse modulo 2^256 block with a self-checking scoreboard.
`timescale 1ns / 1ps

module tb;

  typedef logic [255:0] word256_t;

  // Predicts the inverse of each accepted operand and checks results in order.
  class inverse_scoreboard;
    inv256_pkg::inverse_t pending_inverses[$];
    int mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Newton lifting: a = 2 - v, c = v * a, then refine until the error exponent reaches 256.
    function inv256_pkg::inverse_t predict_inverse(inv256_pkg::value_t v);
      inv256_pkg::inverse_t r;
      word256_t x, a, c, b, low_minus_one;
      int exponent;
      r = '0;
      x = {v.value_limb3, v.value_limb2, v.value_limb1, v.value_limb0};
      if (!x[0]) begin
        r.not_invertible = 1'b1;
        return r;
      end
      low_minus_one = word256_t'(v.value_limb0 - 64'd1);
      exponent = 64;
      for (int i = 63; i >= 0; i--) begin
        if (low_minus_one[i]) exponent = i;
      end
      a = word256_t'(2) - x;
      c = x * a;
      exponent = 2 * exponent;
      while (exponent < 256) begin
        b = word256_t'(2) - c;
        c = c * b;
        a = a * b;
        exponent = 2 * exponent;
      end
      {r.inverse_limb3, r.inverse_limb2, r.inverse_limb1, r.inverse_limb0} = a;
      return r;
    endfunction

    function void note_operand(inv256_pkg::value_t v);
      pending_inverses.push_back(predict_inverse(v));
    endfunction

    function void check_inverse(inv256_pkg::inverse_t got);
      inv256_pkg::inverse_t want;
      if (pending_inverses.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", got);
        return;
      end
      want = pending_inverses.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected %h / %b, got %h / %b",
                   {want.inverse_limb3, want.inverse_limb2, want.inverse_limb1,
                    want.inverse_limb0}, want.not_invertible,
                   {got.inverse_limb3, got.inverse_limb2, got.inverse_limb1,
                    got.inverse_limb0}, got.not_invertible);
      end
    endfunction
  endclass

  localparam int NUM_RANDOM = 1630;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic value_valid = 1'b0;
  logic value_ready;
  inv256_pkg::value_t value = '0;
  logic inverse_valid;
  logic inverse_ready = 1'b0;
  inv256_pkg::inverse_t inverse;

  inverse_scoreboard scoreboard = new();
  bit quiet_tail = 1'b0;
  int cycle_count = 0;

  inverse_mod_2_pow_256 dut (
    .clk(clk),
    .rst(rst),
    .value_valid(value_valid),
    .value_ready(value_ready),
    .value(value),
    .inverse_valid(inverse_valid),
    .inverse_ready(inverse_ready),
    .inverse(inverse)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Sample accepted beats on both channels.
  always @(posedge clk) begin
    if (!rst && value_valid && value_ready) scoreboard.note_operand(value);
    if (!rst && inverse_valid && inverse_ready) scoreboard.check_inverse(inverse);
  end

  // Receiver: random stall bursts until the quiet tail.
  always @(posedge clk) begin
    int stall_left;
    if (rst) begin
      inverse_ready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0 && !quiet_tail) begin
      inverse_ready <= 1'b0;
      stall_left--;
    end else begin
      inverse_ready <= 1'b1;
      if (!quiet_tail && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 5);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Present one operand beat and hold it until accepted; valid drops only for idling.
  task automatic send_operand(inv256_pkg::value_t v);
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      value_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    value_valid <= 1'b1;
    value <= v;
    do @(posedge clk); while (!value_ready);
  endtask

  function automatic logic [63:0] random_limb();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: r = '0;
      1: r = '1;
      2: r = 64'd1 << $urandom_range(0, 63);
      default: ;
    endcase
    return r;
  endfunction

  function automatic inv256_pkg::value_t random_operand();
    inv256_pkg::value_t v;
    v.value_limb0 = random_limb();
    v.value_limb1 = random_limb();
    v.value_limb2 = random_limb();
    v.value_limb3 = random_limb();
    // Mostly odd operands; a few even ones exercise the flag.
    if ($urandom_range(0, 9) != 0) v.value_limb0[0] = 1'b1;
    // Sometimes force a long run of zeros above bit 0 to vary the starting exponent.
    if ($urandom_range(0, 3) == 0)
      v.value_limb0 = (v.value_limb0 << $urandom_range(1, 63)) | 64'd1;
    return v;
  endfunction

  initial begin
    inv256_pkg::value_t v;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed operands: one, all ones, even values, extreme limb patterns.
    send_operand('{64'd0, 64'd0, 64'd0, 64'd1});
    send_operand('{'1, '1, '1, '1});
    send_operand('{64'd0, 64'd0, 64'd0, 64'd0});
    send_operand('{'1, '1, '1, 64'hFFFF_FFFF_FFFF_FFFE});
    send_operand('{64'd0, 64'd0, 64'd0, 64'd3});
    send_operand('{64'd0, 64'd0, 64'd0, 64'h8000_0000_0000_0001});
    send_operand('{'1, '1, '1, 64'd1});
    send_operand('{64'h8000_0000_0000_0000, 64'd0, 64'd0, 64'd1});
    send_operand('{64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                   64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAB});
    send_operand('{64'h8000_0000_0000_0000, 64'd0, 64'd0, 64'd0});
    send_operand('{64'd0, 64'd0, 64'd0, 64'h0000_0001_0000_0001});
    send_operand('{64'd0, 64'd0, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF});
    send_operand('{64'd7, 64'd0, 64'd0, 64'd5});
    for (int k = 1; k < 64; k += 9) send_operand('{64'd0, 64'd0, 64'd0, (64'd1 << k) | 64'd1});
    value_valid <= 1'b0;

    // Hold the sender off until the pipeline has fully drained.
    wait (scoreboard.pending_inverses.size() == 0);
    @(posedge clk);

    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == NUM_RANDOM - 150) quiet_tail = 1'b1;
      v = random_operand();
      send_operand(v);
    end
    value_valid <= 1'b0;

    // Drain, then allow the pipeline latency to expose any stray beat.
    wait (scoreboard.pending_inverses.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (scoreboard.mismatches == 0 && scoreboard.pending_inverses.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/inv256_pkg.sv
hw/rtl/inv256_stage.sv
hw/rtl/inverse_mod_2_pow_256.sv
dv/inverse_mod_2_pow_256_tb.sv
